// File: hw/rtl/fte_pkg.sv
// Shared types and constants of the FAT12 table engine.
// Command and result words, memory request struct, function and status codes.
// No dependencies.
`default_nettype none

package fte_pkg;

    localparam int ENTRIES     = 4096;
    localparam int PAIRS       = ENTRIES / 2;
    localparam int PAIR_W      = $clog2(PAIRS);
    localparam int TABLE_BYTES = PAIRS * 3;
    localparam int LANES       = 3;
    localparam int ENTRY_W     = 12;
    localparam int INDEX_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP3      = (2 ** RECIP_SHIFT + 2) / 3;
    localparam int PROD_W      = INDEX_W + 16;

    localparam logic [ENTRY_W-1:0] END_MARK    = 12'hFFF;
    localparam logic [INDEX_W-1:0] SIZE_RESET  = 13'd4096;
    localparam logic [INDEX_W-1:0] ENTRY_LIMIT = INDEX_W'(ENTRIES);
    localparam logic [INDEX_W-1:0] BYTE_LIMIT  = INDEX_W'(TABLE_BYTES);

    localparam logic [2:0] FUNC_LOAD_BYTE  = 3'd0;
    localparam logic [2:0] FUNC_READ_ENTRY = 3'd1;
    localparam logic [2:0] FUNC_ALLOCATE   = 3'd2;
    localparam logic [2:0] FUNC_FREE       = 3'd3;
    localparam logic [2:0] FUNC_COUNT      = 3'd4;
    localparam logic [2:0] FUNC_READ_BYTE  = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RSVD  = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [INDEX_W-1:0] byte_index;
        logic [7:0]         byte_value;
        logic [ENTRY_W-1:0] entry_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] entry_value;
        logic [ENTRY_W-1:0] result_index;
        logic [INDEX_W-1:0] chain_count;
        logic [7:0]         byte_out;
    } res_t;

    typedef struct packed {
        logic [PAIR_W-1:0]           addr;
        logic [LANES-1:0]            we;
        logic [LANES-1:0][7:0]       wdata;
    } mem_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/fat12_table_engine_core.sv
// Top level of the FAT12 table engine: sequencer and three byte-lane RAMs.
// Uses fte_pkg, fte_ctrl and fte_ram.
//
// A word is taken when start is high and busy is low; its result appears on
// result with done high for one cycle, and the receiver cannot hold it off.
// Entries are stored as pairs, one RAM lane for each of the three bytes of a
// pair, so one RAM read fetches two whole entries. Load byte and the codes
// that only report a status finish in the decode state; read entry, read
// byte and free go on to the access state (one RAM read, then for free the
// write-back). Allocate and count read one entry pair at a time from the
// single RAM read port, at most ceil(min(table_size, 4096)/2) pairs, at least one.
// The table RAM is not cleared after reset.
`default_nettype none

module fat12_table_engine_core
    import fte_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire cmd_t               cmd,
    output logic                    busy,
    output logic                    done,
    output res_t                    result,
    input  wire logic               cfg_we,
    input  wire logic [INDEX_W-1:0] cfg_data
);

    mem_req_t              mem_req;
    logic [LANES-1:0][7:0] rdata;

    fte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .mem_req  (mem_req),
        .rdata    (rdata)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        fte_ram #(
            .DEPTH (PAIRS),
            .WIDTH (8)
        ) u_ram (
            .clk   (clk),
            .we    (mem_req.we[g]),
            .addr  (mem_req.addr),
            .wdata (mem_req.wdata[g]),
            .rdata (rdata[g])
        );
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a word in flight");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results back to back");

    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STAT_FULL)) |-> (result.result_index == '0))
        else $error("full table with nonzero index");

endmodule

`default_nettype wire

// File: hw/rtl/fte_ram.sv
// Generic single-port synchronous RAM, read-first, with a registered read port.
// No dependencies.
`default_nettype none

module fte_ram #(
    parameter int DEPTH  = 2048,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/fte_ctrl.sv
// Sequencer of the FAT12 table engine: decode, byte split, entry unpack,
// read-modify-write and the allocate/count scans. Uses fte_pkg.
`default_nettype none

module fte_ctrl
    import fte_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire cmd_t                  cmd,
    output logic                       busy,
    output logic                       done,
    output res_t                       result,
    input  wire logic                  cfg_we,
    input  wire logic [INDEX_W-1:0]    cfg_data,
    output mem_req_t                   mem_req,
    input  wire logic [LANES-1:0][7:0] rdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_ACCESS = 4'b0100,
        S_SCAN   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [INDEX_W-1:0] size_reg, size_next;
    logic [PAIR_W-1:0]  ptr_reg, ptr_next;
    logic [INDEX_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;
    res_t               result_reg, result_next;

    logic [INDEX_W-1:0]        limit;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-RECIP_SHIFT-1:0] quot;
    logic [INDEX_W-1:0]        rem_full;
    logic [1:0]                lane;
    logic [PAIR_W-1:0]         byte_pair;
    logic [PAIR_W-1:0]         entry_pair;
    logic                      byte_ok;
    logic                      eidx_ok;
    logic [7:0]                b0, b1, b2;
    logic [ENTRY_W-1:0]        e0, e1;
    logic [INDEX_W-1:0]        idx0, idx1, idx2;
    logic                      v0, v1, more;
    logic [PAIR_W-1:0]         ptr_inc;
    logic [INDEX_W-1:0]        c0, c1;
    logic                      fin;
    res_t                      res;

    assign limit      = (size_reg > ENTRY_LIMIT) ? ENTRY_LIMIT : size_reg;
    assign prod       = PROD_W'(cmd_reg.byte_index) * PROD_W'(RECIP3);
    assign quot       = prod[PROD_W-1:RECIP_SHIFT];
    assign rem_full   = cmd_reg.byte_index - (INDEX_W'({quot, 1'b0}) + INDEX_W'(quot));
    assign lane       = rem_full[1:0];
    assign byte_pair  = quot[PAIR_W-1:0];
    assign entry_pair = cmd_reg.entry_index[PAIR_W:1];
    assign byte_ok    = cmd_reg.byte_index < BYTE_LIMIT;
    assign eidx_ok    = INDEX_W'(cmd_reg.entry_index) < limit;

    assign b0 = rdata[0];
    assign b1 = rdata[1];
    assign b2 = rdata[2];
    assign e0 = {b1[3:0], b0};
    assign e1 = {b2, b1[7:4]};

    assign idx0    = INDEX_W'({ptr_reg, 1'b0});
    assign idx1    = idx0 + INDEX_W'(1);
    assign idx2    = idx0 + INDEX_W'(2);
    assign v0      = idx0 < limit;
    assign v1      = idx1 < limit;
    assign more    = idx2 < limit;
    assign ptr_inc = ptr_reg + PAIR_W'(1);
    assign c0      = INDEX_W'(e0 == END_MARK);
    assign c1      = INDEX_W'(e1 == END_MARK);

    assign size_next = cfg_we ? cfg_data : size_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        mem_req.addr  = ptr_reg;
        mem_req.we    = '0;
        mem_req.wdata = '0;
        fin           = 1'b0;
        res           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (cmd_reg.func)
                    FUNC_LOAD_BYTE:
                    begin
                        fin = 1'b1;
                        if (byte_ok)
                        begin
                            mem_req.addr        = byte_pair;
                            mem_req.we[lane]    = 1'b1;
                            mem_req.wdata[lane] = cmd_reg.byte_value;
                        end
                        else
                        begin
                            res.status = STAT_RANGE;
                        end
                    end
                    FUNC_READ_ENTRY:
                    begin
                        if (eidx_ok)
                        begin
                            mem_req.addr = entry_pair;
                            state_next   = S_ACCESS;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            res.status = STAT_RANGE;
                        end
                    end
                    FUNC_ALLOCATE, FUNC_COUNT:
                    begin
                        mem_req.addr = '0;
                        ptr_next     = '0;
                        count_next   = '0;
                        state_next   = S_SCAN;
                    end
                    FUNC_FREE:
                    begin
                        if (cmd_reg.entry_index < ENTRY_W'(2))
                        begin
                            fin        = 1'b1;
                            res.status = STAT_RSVD;
                        end
                        else if (!eidx_ok)
                        begin
                            fin        = 1'b1;
                            res.status = STAT_RANGE;
                        end
                        else
                        begin
                            mem_req.addr = entry_pair;
                            state_next   = S_ACCESS;
                        end
                    end
                    FUNC_READ_BYTE:
                    begin
                        if (byte_ok)
                        begin
                            mem_req.addr = byte_pair;
                            state_next   = S_ACCESS;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            res.status = STAT_RANGE;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_ACCESS:
            begin
                fin = 1'b1;
                case (cmd_reg.func)
                    FUNC_READ_ENTRY:
                    begin
                        res.entry_value = cmd_reg.entry_index[0] ? e1 : e0;
                    end
                    FUNC_FREE:
                    begin
                        mem_req.addr = entry_pair;
                        if (cmd_reg.entry_index[0])
                        begin
                            mem_req.we       = 3'b110;
                            mem_req.wdata[1] = {4'h0, b1[3:0]};
                            mem_req.wdata[2] = 8'h00;
                        end
                        else
                        begin
                            mem_req.we       = 3'b011;
                            mem_req.wdata[0] = 8'h00;
                            mem_req.wdata[1] = {b1[7:4], 4'h0};
                        end
                    end
                    FUNC_READ_BYTE:
                    begin
                        res.byte_out = rdata[lane];
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end
            S_SCAN:
            begin
                case (cmd_reg.func)
                    FUNC_ALLOCATE:
                    begin
                        if (v0 && (e0 == '0))
                        begin
                            fin              = 1'b1;
                            mem_req.we       = 3'b011;
                            mem_req.wdata[0] = 8'hFF;
                            mem_req.wdata[1] = {b1[7:4], 4'hF};
                            res.result_index = idx0[ENTRY_W-1:0];
                        end
                        else if (v1 && (e1 == '0))
                        begin
                            fin              = 1'b1;
                            mem_req.we       = 3'b110;
                            mem_req.wdata[1] = {4'hF, b1[3:0]};
                            mem_req.wdata[2] = 8'hFF;
                            res.result_index = idx1[ENTRY_W-1:0];
                        end
                        else if (!more)
                        begin
                            fin        = 1'b1;
                            res.status = STAT_FULL;
                        end
                        else
                        begin
                            mem_req.addr = ptr_inc;
                            ptr_next     = ptr_inc;
                        end
                    end
                    FUNC_COUNT:
                    begin
                        if (!v0 || (e0 == '0))
                        begin
                            fin             = 1'b1;
                            res.chain_count = count_reg;
                        end
                        else if (!v1 || (e1 == '0))
                        begin
                            fin             = 1'b1;
                            res.chain_count = count_reg + c0;
                        end
                        else if (!more)
                        begin
                            fin             = 1'b1;
                            res.chain_count = count_reg + c0 + c1;
                        end
                        else
                        begin
                            count_next   = count_reg + c0 + c1;
                            mem_req.addr = ptr_inc;
                            ptr_next     = ptr_inc;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            result_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= SIZE_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ptr_reg    <= ptr_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: test/fat12_table_engine_core_tb.sv
// Testbench for fat12_table_engine_core: directed and random command words,
// each checked against an in-bench model of the packed FAT12 table.
// Depends on fte_pkg and the engine RTL.
`default_nettype none

module fat12_table_engine_core_tb;
    import fte_pkg::*;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    localparam int FILL_ENTRIES = 128;
    localparam int FILL_BYTES   = (FILL_ENTRIES / 2) * 3;
    localparam int GUARD        = FILL_ENTRIES - 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    cmd_t               cmd = '0;
    logic               busy;
    logic               done;
    res_t               result;
    logic               cfg_we = 1'b0;
    logic [INDEX_W-1:0] cfg_data = '0;

    logic [7:0]         fat_bytes [0:TABLE_BYTES-1];
    logic [INDEX_W-1:0] size_reg = SIZE_RESET;
    res_t               pending_res [$];
    bit                 idle_on = 1'b0;
    int                 err_count = 0;

    fat12_table_engine_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [ENTRY_W-1:0] entry_get(int idx);
        int base;
        base = (idx / 2) * 3;
        if (idx % 2 == 0)
            return {fat_bytes[base+1][3:0], fat_bytes[base]};
        return {fat_bytes[base+2], fat_bytes[base+1][7:4]};
    endfunction

    function automatic void entry_put(int idx, logic [ENTRY_W-1:0] v);
        int base;
        base = (idx / 2) * 3;
        if (idx % 2 == 0)
        begin
            fat_bytes[base]        = v[7:0];
            fat_bytes[base+1][3:0] = v[11:8];
        end
        else
        begin
            fat_bytes[base+1][7:4] = v[3:0];
            fat_bytes[base+2]      = v[11:4];
        end
    endfunction

    function automatic res_t fat_apply(cmd_t w);
        res_t               r;
        int                 lim;
        int                 i;
        logic [ENTRY_W-1:0] e;
        r = '0;
        lim = (size_reg > ENTRY_LIMIT) ? ENTRIES : int'(size_reg);
        case (w.func)
            FUNC_LOAD_BYTE:
                if (w.byte_index < BYTE_LIMIT)
                    fat_bytes[w.byte_index] = w.byte_value;
                else
                    r.status = STAT_RANGE;
            FUNC_READ_ENTRY:
                if (int'(w.entry_index) < lim)
                    r.entry_value = entry_get(int'(w.entry_index));
                else
                    r.status = STAT_RANGE;
            FUNC_ALLOCATE:
            begin
                r.status = STAT_FULL;
                for (i = 0; i < lim; i++)
                begin
                    if (entry_get(i) == '0)
                    begin
                        entry_put(i, END_MARK);
                        r.result_index = ENTRY_W'(i);
                        r.status = STAT_OK;
                        break;
                    end
                end
            end
            FUNC_FREE:
                if (w.entry_index < 2)
                    r.status = STAT_RSVD;
                else if (int'(w.entry_index) >= lim)
                    r.status = STAT_RANGE;
                else
                    entry_put(int'(w.entry_index), '0);
            FUNC_COUNT:
                for (i = 0; i < lim; i++)
                begin
                    e = entry_get(i);
                    if (e == '0)
                        break;
                    if (e == END_MARK)
                        r.chain_count = r.chain_count + 1'b1;
                end
            FUNC_READ_BYTE:
                if (w.byte_index < BYTE_LIMIT)
                    r.byte_out = fat_bytes[w.byte_index];
                else
                    r.status = STAT_RANGE;
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void note_error(string what, logic [15:0] exp_v, logic [15:0] got_v);
        if (err_count < 10)
            $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endfunction

    function automatic void cmp_field(string what, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v)
            note_error(what, exp_v, got_v);
    endfunction

    always @(posedge clk)
    begin : check_words
        res_t want;
        if (rst_n && done)
        begin
            if (pending_res.size() == 0)
                note_error("unexpected word, status", '0, 16'(result.status));
            else
            begin
                want = pending_res.pop_front();
                cmp_field("status", 16'(want.status), 16'(result.status));
                cmp_field("entry_value", 16'(want.entry_value), 16'(result.entry_value));
                cmp_field("result_index", 16'(want.result_index), 16'(result.result_index));
                cmp_field("chain_count", 16'(want.chain_count), 16'(result.chain_count));
                cmp_field("byte_out", 16'(want.byte_out), 16'(result.byte_out));
            end
        end
    end

    function automatic cmd_t pack_word(logic [2:0] f, int bi, int bv, int ei);
        cmd_t w;
        w.func        = f;
        w.byte_index  = bi[INDEX_W-1:0];
        w.byte_value  = bv[7:0];
        w.entry_index = ei[ENTRY_W-1:0];
        return w;
    endfunction

    function automatic cmd_t rand_word();
        return pack_word(3'($urandom_range(0, 7)), $urandom_range(0, 8191),
                         $urandom_range(0, 255), $urandom_range(0, 4095));
    endfunction

    task automatic send_word(cmd_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        pending_res.push_back(fat_apply(w));
    endtask

    task automatic send_op(logic [2:0] f, int bi, int bv, int ei);
        send_word(pack_word(f, bi, bv, ei));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_table_size(logic [INDEX_W-1:0] v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_reg = v;
    endtask

    task automatic test_table_fill();
        int i;
        idle_on = 1'b0;
        for (i = 0; i < FILL_BYTES; i++)
            send_op(FUNC_LOAD_BYTE, i, 8'hFF, 0);
        for (i = TABLE_BYTES - 3; i < TABLE_BYTES; i++)
            send_op(FUNC_LOAD_BYTE, i, 8'hFF, 0);
    endtask

    task automatic test_reset_size();
        send_op(FUNC_READ_ENTRY, 0, 0, 4095);
        send_op(FUNC_FREE, 0, 0, 4095);
        send_op(FUNC_FREE, 0, 0, GUARD);
        send_op(FUNC_COUNT, 0, 0, 0);
        send_op(FUNC_ALLOCATE, 0, 0, 0);
        send_op(FUNC_FREE, 0, 0, GUARD);
        send_op(FUNC_READ_ENTRY, 0, 0, 0);
    endtask

    task automatic test_byte_and_entry_access();
        idle_on = 1'b1;
        send_op(FUNC_LOAD_BYTE, 0, 8'h00, 0);
        send_op(FUNC_LOAD_BYTE, 1, 8'h00, 0);
        send_op(FUNC_READ_ENTRY, 0, 0, 0);
        send_op(FUNC_READ_ENTRY, 0, 0, 1);
        send_op(FUNC_ALLOCATE, 0, 0, 0);
        send_op(FUNC_READ_BYTE, 0, 0, 0);
        send_op(FUNC_READ_BYTE, 1, 0, 0);
        send_op(FUNC_LOAD_BYTE, TABLE_BYTES - 1, 8'hA5, 0);
        send_op(FUNC_READ_BYTE, TABLE_BYTES - 1, 0, 0);
        send_op(FUNC_READ_ENTRY, 0, 0, 4095);
        send_op(FUNC_LOAD_BYTE, TABLE_BYTES, 8'h5A, 0);
        send_op(FUNC_LOAD_BYTE, 8191, 8'hFF, 4095);
        send_op(FUNC_READ_BYTE, 8191, 0, 0);
        send_op(FUNC_FREE, 0, 0, 0);
        send_op(FUNC_FREE, 0, 0, 1);
        send_op(FUNC_FREE, 0, 0, 4095);
        send_op(FUNC_READ_ENTRY, 0, 0, 4095);
        send_op(FUNC_SPARE_LO, 8191, 8'hFF, 4095);
        send_op(FUNC_SPARE_HI, $urandom_range(0, 8191), $urandom_range(0, 255),
                $urandom_range(0, 4095));
        send_op(FUNC_COUNT, 0, 0, 0);
    endtask

    task automatic test_size_extremes();
        write_table_size(13'd2);
        send_op(FUNC_ALLOCATE, 0, 0, 0);
        send_op(FUNC_FREE, 0, 0, 1);
        send_op(FUNC_FREE, 0, 0, 2);
        send_op(FUNC_READ_ENTRY, 0, 0, 1);
        send_op(FUNC_READ_ENTRY, 0, 0, 2);
        send_op(FUNC_COUNT, 0, 0, 0);
        write_table_size(13'd0);
        send_op(FUNC_ALLOCATE, 0, 0, 0);
        send_op(FUNC_COUNT, 0, 0, 0);
        send_op(FUNC_READ_ENTRY, 0, 0, 0);
        send_op(FUNC_FREE, 0, 0, 0);
        send_op(FUNC_FREE, 0, 0, 4095);
        write_table_size(13'd1);
        send_op(FUNC_READ_ENTRY, 0, 0, 0);
        send_op(FUNC_ALLOCATE, 0, 0, 0);
        send_op(FUNC_COUNT, 0, 0, 0);
        write_table_size(13'd8191);
        send_op(FUNC_READ_ENTRY, 0, 0, 4095);
        send_op(FUNC_COUNT, 0, 0, 0);
        send_op(FUNC_ALLOCATE, 0, 0, 0);
        write_table_size(SIZE_RESET);
        send_op(FUNC_FREE, 0, 0, GUARD);
        send_op(FUNC_FREE, 0, 0, 4095);
        send_op(FUNC_COUNT, 0, 0, 0);
        write_table_size(13'd4097);
        send_op(FUNC_READ_ENTRY, 0, 0, 4095);
    endtask

    task automatic test_random_ops(int target);
        int                 sent;
        int                 lim;
        int                 span;
        int                 len;
        int                 k;
        int                 pick;
        logic [INDEX_W-1:0] sz;
        cmd_t               w;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                sz = INDEX_W'($urandom_range(2, 64));
            else if (pick < 8)
                sz = INDEX_W'($urandom_range(0, FILL_ENTRIES));
            else
                sz = INDEX_W'($urandom_range(65, FILL_ENTRIES));
            write_table_size(sz);
            lim = (sz > ENTRY_LIMIT) ? ENTRIES : int'(sz);
            span = ((lim + 1) / 2) * 3;
            if (span == 0)
                span = 3;
            idle_on = ($urandom_range(0, 3) != 0);
            len = $urandom_range(15, 40);
            for (k = 0; k < len; k++)
            begin
                w = rand_word();
                if ($urandom_range(0, 9) < 7)
                begin
                    case ($urandom_range(0, 9))
                        0, 1:
                        begin
                            w.func = FUNC_LOAD_BYTE;
                            w.byte_index = INDEX_W'($urandom_range(0, span - 1));
                            if ($urandom_range(0, 1) == 0)
                                w.byte_value = 8'h00;
                        end
                        2, 3, 4:
                            w.func = FUNC_ALLOCATE;
                        5, 6:
                        begin
                            w.func = FUNC_FREE;
                            if (lim > 2)
                                w.entry_index = ENTRY_W'($urandom_range(2, lim - 1));
                        end
                        7:
                        begin
                            w.func = FUNC_READ_ENTRY;
                            if (lim > 0)
                                w.entry_index = ENTRY_W'($urandom_range(0, lim - 1));
                        end
                        8:
                            w.func = FUNC_COUNT;
                        default:
                        begin
                            w.func = FUNC_READ_BYTE;
                            w.byte_index = INDEX_W'($urandom_range(0, span - 1));
                        end
                    endcase
                end
                else if ((w.func == FUNC_READ_BYTE) && (w.byte_index < BYTE_LIMIT))
                begin
                    w.byte_index = INDEX_W'($urandom_range(0, span - 1));
                end
                send_word(w);
                sent++;
            end
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_reset_size();
        test_byte_and_entry_access();
        test_size_extremes();
        test_random_ops(800);
        settle();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
